### src/refcounted_key_table_with_id_allocator_defines.svh
// Assertion macros for the glyph key table.
// Included by the modules that carry concurrent checks; needs nothing else.
`ifndef REFCOUNTED_KEY_TABLE_WITH_ID_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_KEY_TABLE_WITH_ID_ALLOCATOR_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define RKT_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define RKT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

### src/rkt_pkg.sv
// Shared types and constants for the glyph key table.
// No dependencies.
`timescale 1ns / 1ps
package rkt_pkg;
	localparam int DEPTH   = 256;
	localparam int ID_W    = 8;
	localparam int PTR_W   = 9;
	localparam int CNT_W   = 16;
	localparam int KEY_W   = 40;

	localparam logic [2:0] CMD_REGISTER = 3'd0;
	localparam logic [2:0] CMD_REMOVE   = 3'd1;
	localparam logic [2:0] CMD_QUERY    = 3'd2;
	localparam logic [2:0] CMD_INC      = 3'd3;
	localparam logic [2:0] CMD_DEC      = 3'd4;
	localparam logic [2:0] CMD_ID2KEY   = 3'd5;

	localparam logic [2:0] ST_DONE      = 3'd0;
	localparam logic [2:0] ST_NOCHANGE  = 3'd1;
	localparam logic [2:0] ST_NOTFOUND  = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_UNDERFLOW = 3'd4;

	typedef struct packed {
		logic load;
		logic scan_en;
		logic id_rd;
		logic cap;
		logic exec;
	} rkt_ctl_t;

	typedef struct packed {
		logic rd_vld;
		logic match;
		logic last;
	} rkt_sts_t;
endpackage

### src/rkt_ctrl.sv
// Sequencer for the glyph key table: accept, scan or look up as the command needs, execute, respond.
// Depends on rkt_pkg.
`timescale 1ns / 1ps
module rkt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        command,
	output logic              out_valid,
	input  logic              out_ready,
	input  rkt_pkg::rkt_sts_t sts,
	output rkt_pkg::rkt_ctl_t ctl
);
	import rkt_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_LOOK = 3'd2;
	localparam logic [2:0] S_WAIT = 3'd3;
	localparam logic [2:0] S_EXEC = 3'd4;
	localparam logic [2:0] S_RESP = 3'd5;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		ctl = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					if (command inside {[CMD_REGISTER:CMD_DEC]})
						state_d = S_SCAN;
					else if (command == CMD_ID2KEY)
						state_d = S_LOOK;
					else
						state_d = S_EXEC;
				end
			end
			S_SCAN: begin
				ctl.scan_en = 1'b1;
				if (sts.rd_vld && (sts.match || sts.last)) begin
					ctl.cap = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_LOOK: begin
				ctl.id_rd = 1'b1;
				state_d = S_WAIT;
			end
			S_WAIT: begin
				ctl.cap = 1'b1;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				ctl.exec = 1'b1;
				state_d = S_RESP;
			end
			S_RESP: begin
				out_valid = 1'b1;
				if (out_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end
endmodule

### src/rkt_dp.sv
// Datapath for the glyph key table: key, count and free-ID memories, valid bits,
// scan pipeline, allocator pointers and result registers. Depends on rkt_pkg.
`timescale 1ns / 1ps
`include "refcounted_key_table_with_id_allocator_defines.svh"
module rkt_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rkt_pkg::rkt_ctl_t          ctl,
	output rkt_pkg::rkt_sts_t          sts,
	input  logic [2:0]                 command,
	input  logic [7:0]                 font_face,
	input  logic [15:0]                font_size,
	input  logic [15:0]                glyph_index,
	input  logic [rkt_pkg::ID_W-1:0]   glyph_id,
	output logic [2:0]                 status,
	output logic                       found,
	output logic [rkt_pkg::ID_W-1:0]   result_id,
	output logic [7:0]                 key_face,
	output logic [15:0]                key_size,
	output logic [15:0]                key_index,
	output logic [rkt_pkg::CNT_W-1:0]  ref_count,
	output logic                       removed
);
	import rkt_pkg::*;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(DEPTH);

	logic [KEY_W-1:0] key_mem [DEPTH];
	logic [CNT_W-1:0] cnt_mem [DEPTH];
	logic [ID_W-1:0]  stk_mem [DEPTH];
	logic [DEPTH-1:0] valid_q;

	logic [2:0]       cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [ID_W-1:0]  gid_q, idx_q;
	logic [PTR_W-1:0] depth_q, fresh_q;

	logic             rd_vld_s1;
	logic [ID_W-1:0]  rd_idx_s1, rd_addr, top_idx;
	logic [KEY_W-1:0] key_rd_s1, keyv_q;
	logic [CNT_W-1:0] cnt_rd_s1, cntv_q;
	logic [ID_W-1:0]  stk_rd_s1, slot_q;
	logic             hit_q, hit_now, match;

	logic             pop, push, fresh_inc, set_v, clr_v, key_we, cnt_we;
	logic [ID_W-1:0]  wr_slot;
	logic [CNT_W-1:0] cnt_wd;
	logic [2:0]       st_d;
	logic             fnd_d, rem_d;
	logic [ID_W-1:0]  rid_d;
	logic [KEY_W-1:0] kout_d;
	logic [CNT_W-1:0] cnt_d;

	assign rd_addr = ctl.id_rd ? gid_q : idx_q;
	assign top_idx = depth_q[ID_W-1:0] - 1'b1;
	assign match   = valid_q[rd_idx_s1] && (key_rd_s1 == key_q);
	assign hit_now = (cmd_q == CMD_ID2KEY) ? valid_q[rd_idx_s1] : match;

	assign sts.rd_vld = rd_vld_s1;
	assign sts.match  = match;
	assign sts.last   = (rd_idx_s1 == ID_W'(DEPTH - 1));

	always_ff @(posedge clk) begin
		key_rd_s1 <= key_mem[rd_addr];
		cnt_rd_s1 <= cnt_mem[rd_addr];
		stk_rd_s1 <= stk_mem[top_idx];
		rd_idx_s1 <= rd_addr;
		if (key_we)
			key_mem[wr_slot] <= key_q;
		if (cnt_we)
			cnt_mem[wr_slot] <= cnt_wd;
		if (push)
			stk_mem[depth_q[ID_W-1:0]] <= wr_slot;
		if (ctl.load) begin
			cmd_q <= command;
			key_q <= {font_face, font_size, glyph_index};
			gid_q <= glyph_id;
		end
		if (ctl.cap) begin
			hit_q  <= hit_now;
			slot_q <= rd_idx_s1;
			keyv_q <= key_rd_s1;
			cntv_q <= cnt_rd_s1;
		end
		if (ctl.exec) begin
			status    <= st_d;
			found     <= fnd_d;
			result_id <= rid_d;
			key_face  <= kout_d[39:32];
			key_size  <= kout_d[31:16];
			key_index <= kout_d[15:0];
			ref_count <= cnt_d;
			removed   <= rem_d;
		end
	end

	always_comb begin
		st_d = ST_NOCHANGE; fnd_d = 1'b0; rid_d = '0; kout_d = '0; cnt_d = '0; rem_d = 1'b0;
		pop = 1'b0; push = 1'b0; fresh_inc = 1'b0; set_v = 1'b0; clr_v = 1'b0;
		key_we = 1'b0; cnt_we = 1'b0; cnt_wd = '0; wr_slot = slot_q;
		case (cmd_q)
			CMD_REGISTER: begin
				if (hit_q) begin
					fnd_d = 1'b1; rid_d = slot_q; cnt_d = cntv_q;
				end else if (depth_q != '0 || fresh_q < DEPTH_P) begin
					if (depth_q != '0) begin
						pop = 1'b1; wr_slot = stk_rd_s1;
					end else begin
						fresh_inc = 1'b1; wr_slot = fresh_q[ID_W-1:0];
					end
					set_v = 1'b1; key_we = 1'b1; cnt_we = 1'b1;
					st_d = ST_DONE; rid_d = wr_slot;
				end else begin
					st_d = ST_FULL;
				end
			end
			CMD_REMOVE, CMD_QUERY, CMD_INC, CMD_DEC: begin
				if (!hit_q) begin
					st_d = ST_NOTFOUND;
				end else begin
					fnd_d = 1'b1; rid_d = slot_q; st_d = ST_DONE;
					case (cmd_q)
						CMD_REMOVE: begin
							clr_v = 1'b1; rem_d = 1'b1;
						end
						CMD_QUERY: cnt_d = cntv_q;
						CMD_INC: begin
							if (cntv_q == CNT_MAX) begin
								st_d = ST_NOCHANGE; cnt_d = cntv_q;
							end else begin
								cnt_we = 1'b1; cnt_wd = cntv_q + 1'b1; cnt_d = cnt_wd;
							end
						end
						default: begin
							if (cntv_q == '0) begin
								st_d = ST_UNDERFLOW;
							end else begin
								cnt_we = 1'b1; cnt_wd = cntv_q - 1'b1; cnt_d = cnt_wd;
								if (cnt_wd == '0) begin
									clr_v = 1'b1; rem_d = 1'b1;
								end
							end
						end
					endcase
					push = clr_v && (depth_q < DEPTH_P);
				end
			end
			CMD_ID2KEY: begin
				rid_d = gid_q;
				if (hit_q) begin
					st_d = ST_DONE; fnd_d = 1'b1; kout_d = keyv_q; cnt_d = cntv_q;
				end else begin
					st_d = ST_NOTFOUND;
				end
			end
			default: st_d = ST_NOCHANGE;
		endcase
		if (!ctl.exec) begin
			pop = 1'b0; push = 1'b0; fresh_inc = 1'b0; set_v = 1'b0; clr_v = 1'b0;
			key_we = 1'b0; cnt_we = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			depth_q   <= '0;
			fresh_q   <= '0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= ctl.scan_en || ctl.id_rd;
			if (ctl.load)
				idx_q <= '0;
			else if (ctl.scan_en)
				idx_q <= idx_q + 1'b1;
			if (set_v)
				valid_q[wr_slot] <= 1'b1;
			if (clr_v)
				valid_q[wr_slot] <= 1'b0;
			if (pop)
				depth_q <= depth_q - 1'b1;
			else if (push)
				depth_q <= depth_q + 1'b1;
			if (fresh_inc)
				fresh_q <= fresh_q + 1'b1;
		end
	end

	`RKT_NEVER(a_depth_range, clk, arst_n, depth_q > DEPTH_P, "free stack overrun")
	`RKT_NEVER(a_fresh_range, clk, arst_n, fresh_q > DEPTH_P, "fresh ID overrun")
	`RKT_NEVER(a_stack_vs_fresh, clk, arst_n, depth_q > fresh_q, "more free IDs than issued")
	`RKT_NEVER(a_push_pop, clk, arst_n, push && pop, "push and pop together")
endmodule

### src/refcounted_key_table_with_id_allocator.sv
// Top level of the reference-counted glyph key table with ID allocator.
// Depends on rkt_pkg, rkt_ctrl and rkt_dp.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  in      | to block  | in_valid / in_ready  | command, font_face, font_size,
//          |           |                      | glyph_index, glyph_id
//  out     | from block| out_valid / out_ready| status, found, result_id, key_face,
//          |           |                      | key_size, key_index, ref_count, removed
//
// One item at a time. Key commands scan the key memory one slot per cycle
// through its single read port: a hit ends the scan at its slot, a miss runs
// it to the last slot. Id-to-key reads the slot named by glyph_id; unknown commands skip both.
// in_ready is high only while idle, from the edge of the result transfer on;
// a result holds on the outputs until transferred.
// arst_n clears the valid bits, the free-stack depth and the fresh-ID counter;
// the memories need no clearing pass.
`timescale 1ns / 1ps
module refcounted_key_table_with_id_allocator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [2:0]                command,
	input  logic [7:0]                font_face,
	input  logic [15:0]               font_size,
	input  logic [15:0]               glyph_index,
	input  logic [rkt_pkg::ID_W-1:0]  glyph_id,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [2:0]                status,
	output logic                      found,
	output logic [rkt_pkg::ID_W-1:0]  result_id,
	output logic [7:0]                key_face,
	output logic [15:0]               key_size,
	output logic [15:0]               key_index,
	output logic [rkt_pkg::CNT_W-1:0] ref_count,
	output logic                      removed
);
	import rkt_pkg::*;

	rkt_ctl_t ctl;
	rkt_sts_t sts;

	// Sequence each transfer: scan or look up as the command needs, execute, then hold the result.
	rkt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// Store keys, counts and free IDs; compute and register the result.
	rkt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.command     (command),
		.font_face   (font_face),
		.font_size   (font_size),
		.glyph_index (glyph_index),
		.glyph_id    (glyph_id),
		.status      (status),
		.found       (found),
		.result_id   (result_id),
		.key_face    (key_face),
		.key_size    (key_size),
		.key_index   (key_index),
		.ref_count   (ref_count),
		.removed     (removed)
	);
endmodule

### bench/refcounted_key_table_with_id_allocator_tb.sv
// Self-checking bench for the reference-counted glyph key table with ID allocator.
// Depends on rkt_pkg and the refcounted_key_table_with_id_allocator top level.
`timescale 1ns / 1ps
module refcounted_key_table_with_id_allocator_tb;
	import rkt_pkg::*;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [7:0]  face;
		logic [15:0] size;
		logic [15:0] gidx;
		logic [7:0]  gid;
	} glyph_req_t;

	typedef struct packed {
		logic [2:0]  st;
		logic        fnd;
		logic [7:0]  rid;
		logic [7:0]  kf;
		logic [15:0] ks;
		logic [15:0] ki;
		logic [15:0] cnt;
		logic        rem;
	} glyph_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] command = '0;
	logic [7:0] font_face = '0;
	logic [15:0] font_size = '0;
	logic [15:0] glyph_index = '0;
	logic [7:0] glyph_id = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic found;
	logic [7:0] result_id;
	logic [7:0] key_face;
	logic [15:0] key_size;
	logic [15:0] key_index;
	logic [15:0] ref_count;
	logic removed;

	refcounted_key_table_with_id_allocator dut (.*);

	always #6 clk = ~clk;

	// Shadow copy of the table.
	logic        tbl_valid [DEPTH];
	logic [39:0] tbl_key   [DEPTH];
	logic [15:0] tbl_count [DEPTH];
	logic [7:0]  free_ids  [DEPTH];   // LIFO of freed IDs
	int          free_top;
	int          fresh_id;

	glyph_req_t  pending_reqs [$];
	glyph_rsp_t  awaited_rsps [$];
	glyph_req_t  cur_req;
	int          n_errors;
	bit          quiet_mode;     // long stretch with no idling
	bit          hold_go = 1'b0; // start the receiver hold-off
	bit          hold_rx = 1'b0; // receiver held off

	function automatic glyph_rsp_t table_step(glyph_req_t r);
		glyph_rsp_t o;
		int hit;
		int s;
		logic [39:0] k;
		o = '0;
		o.st = ST_NOCHANGE;
		k = {r.face, r.size, r.gidx};
		hit = -1;
		if (r.cmd <= CMD_DEC)
			for (int i = 0; i < DEPTH; i++)
				if (hit < 0 && tbl_valid[i] && tbl_key[i] == k) hit = i;
		case (r.cmd)
			CMD_REGISTER: begin
				if (hit >= 0) begin
					o.fnd = 1'b1; o.rid = 8'(hit); o.cnt = tbl_count[hit];
				end else begin
					s = -1;
					if (free_top > 0) begin
						free_top--;
						s = int'(free_ids[free_top]);
					end else if (fresh_id < DEPTH) begin
						s = fresh_id; fresh_id++;
					end
					if (s < 0) o.st = ST_FULL;
					else begin
						tbl_valid[s] = 1'b1; tbl_key[s] = k; tbl_count[s] = '0;
						o.st = ST_DONE; o.rid = 8'(s);
					end
				end
			end
			CMD_REMOVE, CMD_QUERY, CMD_INC, CMD_DEC: begin
				if (hit < 0) o.st = ST_NOTFOUND;
				else begin
					o.fnd = 1'b1; o.rid = 8'(hit); o.st = ST_DONE;
					if (r.cmd == CMD_REMOVE) begin
						tbl_valid[hit] = 1'b0; o.rem = 1'b1;
						free_ids[free_top] = 8'(hit); free_top++;
					end else if (r.cmd == CMD_QUERY) o.cnt = tbl_count[hit];
					else if (r.cmd == CMD_INC) begin
						if (tbl_count[hit] == 16'hFFFF) o.st = ST_NOCHANGE;
						else tbl_count[hit]++;
						o.cnt = tbl_count[hit];
					end else if (tbl_count[hit] == 0) o.st = ST_UNDERFLOW;
					else begin
						tbl_count[hit]--;
						o.cnt = tbl_count[hit];
						if (tbl_count[hit] == 0) begin
							tbl_valid[hit] = 1'b0; o.rem = 1'b1;
							free_ids[free_top] = 8'(hit); free_top++;
						end
					end
				end
			end
			CMD_ID2KEY: begin
				o.rid = r.gid;
				if (tbl_valid[r.gid]) begin
					o.st = ST_DONE; o.fnd = 1'b1;
					{o.kf, o.ks, o.ki} = tbl_key[r.gid];
					o.cnt = tbl_count[r.gid];
				end else o.st = ST_NOTFOUND;
			end
			default: ;
		endcase
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0h, want %0h", what, got, want);
		n_errors++;
	endtask

	function automatic glyph_req_t make_req(logic [2:0] c, logic [39:0] k, logic [7:0] g);
		glyph_req_t r;
		r.cmd = c;
		{r.face, r.size, r.gidx} = k;
		r.gid = g;
		return r;
	endfunction

	// Append an item to the driver's queue.
	task automatic queue_req(logic [2:0] c, logic [39:0] k, logic [7:0] g);
		pending_reqs.insert(pending_reqs.size(), make_req(c, k, g));
	endtask

	// Small key pool so lookups hit often; occasionally a wild key.
	function automatic logic [39:0] pick_key();
		if ($urandom_range(0, 9) == 0) return 40'({$urandom, $urandom});
		return {8'($urandom_range(0, 3)), 16'($urandom_range(0, 3)), 16'($urandom_range(0, 7))};
	endfunction

	// Driver: hold valid and payload until transfer, idle at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_ready) begin
				if (pending_reqs.size() > 0 && (quiet_mode || $urandom_range(0, 99) >= 12)) begin
					cur_req = pending_reqs.pop_front();
					awaited_rsps.insert(awaited_rsps.size(), table_step(cur_req));
					in_valid <= 1'b1;
					command <= cur_req.cmd;
					font_face <= cur_req.face;
					font_size <= cur_req.size;
					glyph_index <= cur_req.gidx;
					glyph_id <= cur_req.gid;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// Monitor: compare each transfer with the oldest expectation; drive ready.
	always @(posedge clk) begin
		glyph_rsp_t w;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (awaited_rsps.size() == 0)
					report_mismatch("unexpected result", status, 0);
				else begin
					w = awaited_rsps.pop_front();
					if (status !== w.st) report_mismatch("status", status, w.st);
					if (found !== w.fnd) report_mismatch("found", found, w.fnd);
					if (result_id !== w.rid) report_mismatch("result_id", result_id, w.rid);
					if (key_face !== w.kf) report_mismatch("key_face", key_face, w.kf);
					if (key_size !== w.ks) report_mismatch("key_size", key_size, w.ks);
					if (key_index !== w.ki) report_mismatch("key_index", key_index, w.ki);
					if (ref_count !== w.cnt) report_mismatch("ref_count", ref_count, w.cnt);
					if (removed !== w.rem) report_mismatch("removed", removed, w.rem);
				end
			end
			if (hold_rx)
				out_ready <= 1'b0;
			else
				out_ready <= quiet_mode || $urandom_range(0, 99) >= 12;
		end
	end

	// Receiver hold-off: count the stretch in cycles once started.
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (300) @(posedge clk);
		hold_rx <= 1'b0;
	end

	initial begin
		#50_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		logic [39:0] k;
		for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
		free_top = 0;
		fresh_id = 0;
		n_errors = 0;
		quiet_mode = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes of the key, every command, the special cases.
		queue_req(CMD_ID2KEY, '0, 8'd0);          // never written
		queue_req(CMD_QUERY, '1, 8'd0);           // missing key
		queue_req(CMD_REGISTER, '1, 8'd0);
		queue_req(CMD_REGISTER, '0, 8'd0);
		queue_req(CMD_REGISTER, '1, 8'd0);        // already present
		queue_req(CMD_DEC, '1, 8'd0);             // underflow
		queue_req(CMD_INC, '1, 8'd0);
		queue_req(CMD_INC, '1, 8'd0);
		queue_req(CMD_QUERY, '1, 8'd0);
		queue_req(CMD_ID2KEY, '0, 8'd0);
		queue_req(CMD_ID2KEY, '0, 8'd255);
		queue_req(CMD_DEC, '1, 8'd0);
		queue_req(CMD_DEC, '1, 8'd0);             // to zero, removed
		queue_req(CMD_INC, '0, 8'd0);
		queue_req(CMD_REMOVE, '0, 8'd0);
		queue_req(CMD_REMOVE, '0, 8'd0);          // missing
		queue_req(3'd6, '1, 8'hFF);               // unknown commands
		queue_req(3'd7, '0, 8'h00);
		queue_req(CMD_REGISTER, 40'h55_AAAA_5555, 8'd0); // LIFO reuse
		queue_req(CMD_REGISTER, 40'hAA_5555_AAAA, 8'd0);

		// Hold off the receiver while the sender keeps offering items.
		wait (pending_reqs.size() == 0);
		hold_go = 1'b1;
		for (int i = 0; i < 6; i++)
			queue_req(CMD_ID2KEY, '0, 8'($urandom_range(0, 3)));
		// Pause the sender until every expectation has been met.
		wait (pending_reqs.size() == 0);
		wait (awaited_rsps.size() == 0 && !in_valid);

		// Random: mostly commands on a small key pool.
		for (int i = 0; i < 100; i++) begin
			if (i == 40) quiet_mode = 1'b1;
			if (i == 90) quiet_mode = 1'b0;
			k = pick_key();
			queue_req(3'($urandom_range(0, 7) == 7 ?
				$urandom_range(6, 7) : $urandom_range(0, 5)), k,
				8'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 40)));
			if (i % 40 == 39) wait (pending_reqs.size() < 8);
		end

		// Fill the table to full, probe, remove twenty keys, then register once more.
		wait (pending_reqs.size() == 0);
		for (int i = 0; i < 260; i++)
			queue_req(CMD_REGISTER, {8'hC3, 16'(i), 16'hFFFF}, 8'd0);
		queue_req(CMD_ID2KEY, '0, 8'd255);
		for (int i = 0; i < 20; i++)
			queue_req(CMD_REMOVE, {8'hC3, 16'(i), 16'hFFFF}, 8'd0);
		queue_req(CMD_REGISTER, 40'h01_0203_0405, 8'd0);

		wait (pending_reqs.size() == 0);
		wait (awaited_rsps.size() == 0);
		repeat (300) @(posedge clk);
		if (n_errors == 0 && awaited_rsps.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

### refcounted_key_table_with_id_allocator.f
+incdir+src
src/rkt_pkg.sv
src/rkt_ctrl.sv
src/rkt_dp.sv
src/refcounted_key_table_with_id_allocator.sv
bench/refcounted_key_table_with_id_allocator_tb.sv
